// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the concentric aperture ratio block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CAR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg
// Types and constants shared by the concentric aperture ratio modules.
// ----------------------------------------------------------------------------
package car_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CENTER_COL  = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW  = 3'd1;
  localparam logic [2:0] REG_WINDOW_SIZE = 3'd2;
  localparam logic [2:0] REG_IMAGE_COLS  = 3'd3;
  localparam logic [2:0] REG_IMAGE_ROWS  = 3'd4;
  localparam logic [2:0] REG_BACKGROUND  = 3'd5;

  // Ratio selectors
  localparam logic [1:0] RATIO_INNER  = 2'd0;
  localparam logic [1:0] RATIO_MIDDLE = 2'd1;
  localparam logic [1:0] RATIO_OUTER  = 2'd2;

  // Squared-distance limits of the nested discs (strict less-than)
  localparam int D2_LIM_R11 = 121;
  localparam int D2_LIM_R8  = 64;
  localparam int D2_LIM_R5  = 25;
  localparam int D2_LIM_R2  = 4;

  localparam int SUM_W     = 48;
  localparam int COORD_W   = 14;
  localparam int DIV_STEPS = 33;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [11:0]        center_col;
    logic [11:0]        center_row;
    logic [6:0]         window_size;
    logic [12:0]        image_cols;
    logic [12:0]        image_rows;
    logic signed [31:0] background;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic s1_busy;
    logic core_zero;
    logic out_free;
  } status_t;

endpackage

// File: sv/concentric_aperture_ratios_core.sv
// ----------------------------------------------------------------------------
// concentric_aperture_ratios_core
// Streaming aperture photometry: nested disc sums and ring-to-core ratios.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel with column, row and value; s_tlast marks
//   the final pixel of a window. Pixels in the square window around the
//   configured center (and inside the image) are background-corrected and
//   added to disc sums of radius 2, 5, 8 and 11.
//   Throughput: one pixel per cycle while the window is open.
//   After the last pixel the input stalls for a two-stage drain, then three
//   Q16.16 divisions on one shared restoring divider (33 quotient bits, one
//   per cycle, plus load and store).
//   The result leaves on the m_ channel from an output register; if the
//   receiver stalls it holds there, and a following window's pixels are still
//   taken until that window's result is ready to be loaded.
//   A zero core sum gives zero ratios with core_zero set.
//   Reset clears the sums, the sequencer and the output valid, and restores
//   the register defaults. The user must write registers only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
module concentric_aperture_ratios_core #(
  parameter int MAX_WINDOW = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12], pixel_value[55:24]
  input  logic        s_tlast,   // last_pixel
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // ratio_inner_ring[31:0], ratio_middle_ring[63:32],
                                 // ratio_outer_ring[95:64]
  output logic [1:0]  m_tuser    // core_zero[0], ratio_saturated[1]
);

  car_pkg::cfg_t    cfg;
  car_pkg::cmd_t    cmd;
  car_pkg::status_t status;

  car_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  car_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  car_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sv/car_regs.sv
// ----------------------------------------------------------------------------
// car_regs
// APB configuration registers for the aperture center, window and background.
// ----------------------------------------------------------------------------
module car_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output car_pkg::cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register, ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_col  <= 12'd0;
      cfg.center_row  <= 12'd0;
      cfg.window_size <= 7'd40;
      cfg.image_cols  <= 13'h1000;
      cfg.image_rows  <= 13'h1000;
      cfg.background  <= 32'sd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        car_pkg::REG_CENTER_COL:  cfg.center_col  <= pwdata[11:0];
        car_pkg::REG_CENTER_ROW:  cfg.center_row  <= pwdata[11:0];
        car_pkg::REG_WINDOW_SIZE: cfg.window_size <= pwdata[6:0];
        car_pkg::REG_IMAGE_COLS:  cfg.image_cols  <= pwdata[12:0];
        car_pkg::REG_IMAGE_ROWS:  cfg.image_rows  <= pwdata[12:0];
        car_pkg::REG_BACKGROUND:  cfg.background  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      car_pkg::REG_CENTER_COL:  prdata = {20'd0, cfg.center_col};
      car_pkg::REG_CENTER_ROW:  prdata = {20'd0, cfg.center_row};
      car_pkg::REG_WINDOW_SIZE: prdata = {25'd0, cfg.window_size};
      car_pkg::REG_IMAGE_COLS:  prdata = {19'd0, cfg.image_cols};
      car_pkg::REG_IMAGE_ROWS:  prdata = {19'd0, cfg.image_rows};
      car_pkg::REG_BACKGROUND:  prdata = cfg.background;
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/car_ctrl.sv
// ----------------------------------------------------------------------------
// car_ctrl
// Sequencer: pixel intake, pipeline drain, three shared divisions, result.
// ----------------------------------------------------------------------------
module car_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  car_pkg::status_t  status,
  output car_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DRAIN = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ITER  = 6'b001000,
    ST_STORE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [car_pkg::STEP_W-1:0]  step_cnt, step_cnt_next;
  logic [1:0]                  sel, sel_next;
  logic                        accept;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      sel      <= car_pkg::RATIO_INNER;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      sel      <= sel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    sel_next      = sel;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.sel       = sel;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tlast) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.s1_busy) begin
          sel_next   = car_pkg::RATIO_INNER;
          state_next = status.core_zero ? ST_OUT : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load  = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_ITER;
      end
      ST_ITER: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == car_pkg::STEP_W'(car_pkg::DIV_STEPS - 1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.div_store = 1'b1;
        if (sel == car_pkg::RATIO_OUTER) begin
          state_next = ST_OUT;
        end else begin
          sel_next   = sel + 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: sv/car_dp.sv
// ----------------------------------------------------------------------------
// car_dp
// Datapath: window test, disc accumulators, shared divider, output register.
// ----------------------------------------------------------------------------
module car_dp #(
  parameter int MAX_WINDOW = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  car_pkg::cfg_t     cfg,
  input  car_pkg::cmd_t     cmd,
  output car_pkg::status_t  status,
  input  logic [55:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,
  output logic [1:0]        m_tuser
);

  localparam int CW = car_pkg::COORD_W;
  localparam int SW = car_pkg::SUM_W;

  // Input fields
  logic [11:0]                  pixel_col, pixel_row;
  logic signed [PIXEL_BITS-1:0] pix_low;
  assign pixel_col = s_tdata[11:0];
  assign pixel_row = s_tdata[23:12];
  assign pix_low   = s_tdata[24 +: PIXEL_BITS];

  // Window and disc classification
  logic signed [CW-1:0]   col_s, row_s, cc_s, cr_s, win_w, min_x, min_y;
  logic signed [CW-1:0]   dx, dy;
  logic signed [2*CW:0]   d2;
  logic                   in_win;
  logic [4:0]             mask;
  logic signed [32:0]     pix_v;

  always_comb begin
    col_s = $signed({2'b00, pixel_col});
    row_s = $signed({2'b00, pixel_row});
    cc_s  = $signed({2'b00, cfg.center_col});
    cr_s  = $signed({2'b00, cfg.center_row});
    win_w = ({7'd0, cfg.window_size} > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW)
                                                        : $signed({7'd0, cfg.window_size});
    min_x = cc_s - (win_w >>> 1);
    min_y = cr_s - (win_w >>> 1);
    in_win = (col_s >= min_x) && (col_s < min_x + win_w) &&
             (row_s >= min_y) && (row_s < min_y + win_w) &&
             ({1'b0, pixel_col} < cfg.image_cols) &&
             ({1'b0, pixel_row} < cfg.image_rows);
    dx = col_s - cc_s;
    dy = row_s - cr_s;
    d2 = (2*CW+1)'(dx * dx) + (2*CW+1)'(dy * dy);
    mask[0] = in_win;
    mask[1] = in_win && (d2 < (2*CW+1)'(car_pkg::D2_LIM_R11));
    mask[2] = in_win && (d2 < (2*CW+1)'(car_pkg::D2_LIM_R8));
    mask[3] = in_win && (d2 < (2*CW+1)'(car_pkg::D2_LIM_R5));
    mask[4] = in_win && (d2 < (2*CW+1)'(car_pkg::D2_LIM_R2));
    pix_v = 33'(pix_low) - 33'(cfg.background);
  end

  // Stage 1: hold the classified pixel
  logic               s1_valid;
  logic signed [32:0] s1_v;
  logic [4:0]         s1_mask;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_v    <= pix_v;
      s1_mask <= mask;
    end
  end

  // Stage 2: accumulate into window and disc sums, clear after the result
  logic signed [SW-1:0] window_sum, disc11_sum, disc8_sum, disc5_sum, disc2_sum;
  logic signed [SW-1:0] add_v;
  assign add_v = SW'(s1_v);

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      window_sum <= '0;
      disc11_sum <= '0;
      disc8_sum  <= '0;
      disc5_sum  <= '0;
      disc2_sum  <= '0;
    end else if (s1_valid) begin
      if (s1_mask[0]) window_sum <= window_sum + add_v;
      if (s1_mask[1]) disc11_sum <= disc11_sum + add_v;
      if (s1_mask[2]) disc8_sum  <= disc8_sum + add_v;
      if (s1_mask[3]) disc5_sum  <= disc5_sum + add_v;
      if (s1_mask[4]) disc2_sum  <= disc2_sum + add_v;
    end
  end

  // Operand selection for the shared divider
  logic signed [SW:0]   num;
  logic [SW:0]          num_mag;
  logic [SW-1:0]        den_mag;
  logic [SW-1:0]        rem_init;

  always_comb begin
    case (cmd.sel)
      car_pkg::RATIO_INNER:  num = (SW+1)'(disc5_sum) - (SW+1)'(disc2_sum);
      car_pkg::RATIO_MIDDLE: num = (SW+1)'(disc8_sum) - (SW+1)'(disc5_sum);
      default:               num = (SW+1)'(disc11_sum) - (SW+1)'(disc8_sum);
    endcase
    num_mag  = num[SW] ? (SW+1)'(-num) : num;
    den_mag  = disc2_sum[SW-1] ? SW'(-disc2_sum) : disc2_sum;
    rem_init = SW'(num_mag >> 17);
  end

  // Restoring divider: |num| * 2^16 / |den|, one quotient bit a cycle
  logic [SW-1:0]  div_rem, div_den;
  logic [32:0]    div_q;
  logic           div_ovf, div_neg;
  logic [SW:0]    trial;
  logic           trial_ge;

  assign trial    = {div_rem, div_q[32]};
  assign trial_ge = trial >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem <= rem_init;
      div_den <= den_mag;
      div_q   <= {num_mag[16:0], 16'd0};
      div_ovf <= rem_init >= den_mag;
      div_neg <= num[SW] != disc2_sum[SW-1];
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? SW'(trial - {1'b0, div_den}) : SW'(trial);
      div_q   <= {div_q[31:0], trial_ge};
    end
  end

  // Signed Q16.16 with clipping
  logic [31:0] q_val;
  logic        q_sat;

  always_comb begin
    q_sat = 1'b0;
    if (div_ovf) begin
      q_sat = 1'b1;
      q_val = div_neg ? car_pkg::Q_MIN : car_pkg::Q_MAX;
    end else if (div_neg) begin
      if (div_q > {1'b0, car_pkg::Q_MIN}) begin
        q_sat = 1'b1;
        q_val = car_pkg::Q_MIN;
      end else begin
        q_val = 32'(33'd0 - div_q);
      end
    end else if (div_q[32:31] != 2'b00) begin
      q_sat = 1'b1;
      q_val = car_pkg::Q_MAX;
    end else begin
      q_val = div_q[31:0];
    end
  end

  // Collect the three ratios and the clip flag
  logic [31:0] ratio [3];
  logic        sat_acc;

  always_ff @(posedge clk) begin
    if (cmd.div_load && cmd.sel == car_pkg::RATIO_INNER) sat_acc <= 1'b0;
    else if (cmd.div_store)                               sat_acc <= sat_acc | q_sat;
    if (cmd.div_store) ratio[cmd.sel] <= q_val;
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= status.core_zero ? 96'd0 : {ratio[2], ratio[1], ratio[0]};
      m_tuser <= {sat_acc && !status.core_zero, status.core_zero};
    end
  end

  assign status.s1_busy   = s1_valid;
  assign status.core_zero = (disc2_sum == '0);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

// File: sv/car_checker.sv
// ----------------------------------------------------------------------------
// car_checker
// Port-level checks on the concentric aperture ratio block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module car_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Hold a stalled result
  `CAR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // A zero core gives zero ratios and no clip flag
  `CAR_ASSERT_NOW(a_core_zero, m_tvalid && m_tuser[0], m_tdata == 96'd0 && !m_tuser[1], "core zero with nonzero ratios")

  // Stop taking pixels once a window closes
  `CAR_ASSERT_NEXT(a_last_stall, s_tvalid && s_tready && s_tlast, !s_tready, "pixel taken during ratio computation")

  // Drop the result valid out of reset
  `CAR_ASSERT_ALWAYS_NEXT(a_rst_out, rst, !m_tvalid, "result valid after reset")

endmodule

bind concentric_aperture_ratios_core car_props u_car_props (.*);
